[sv/jpeg_dequant_unzigzag_defines.svh]
// assertion macros for the dequantizer and inverse zigzag block
`ifndef JPEG_DEQUANT_UNZIGZAG_DEFINES_SVH
`define JPEG_DEQUANT_UNZIGZAG_DEFINES_SVH

// same-cycle implication, checked outside reset
`define JDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define JDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/jdq_pkg.sv]
// shared constants, types and the zigzag map of the dequantizer
package jdq_pkg;

	localparam int NUM_TABLES    = 4;
	localparam int BLOCK_ENTRIES = 64;

	localparam int POS_W      = $clog2(BLOCK_ENTRIES);
	localparam int SEL_W      = 2;
	localparam int STEP_W     = 8;
	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = SAMPLE_W + STEP_W + 1;
	localparam int TBL_ADDR_W = $clog2(NUM_TABLES * BLOCK_ENTRIES);
	localparam int BLK_ADDR_W = POS_W + 1;
	localparam int BLK_DEPTH  = 2 * BLOCK_ENTRIES;

	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 24;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_ENTRIES - 1);

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_COEF = 1'b1
	} cmd_t;

	// readout progress seen by the input side
	typedef struct packed {
		logic done;
		logic active;
		logic bank;
	} rd_status_t;

	localparam logic [POS_W-1:0] ZZ_TO_NAT [BLOCK_ENTRIES] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

endpackage

[sv/jpeg_dequant_unzigzag.sv]
// top level: table loads, dequantizing multiply, inverse zigzag store and readout
//
//  port group | direction | word
//  s_axis     | in        | table load or zigzag-order coefficient
//  m_axis     | out       | dequantized sample in natural order, tlast on position 63
//
// one input word per cycle while s_axis_tready is high; loads write the table memory at acceptance,
// coefficients pass a table read, a multiply and a block store write
// after the 64th coefficient the bank is read out, one word per cycle at best
// two banks alternate: input stalls only when the bank it would fill has not yet been read out
// reset clears counters, bank flags and valids; table and block memories start unknown
`include "jpeg_dequant_unzigzag_defines.svh"

module jpeg_dequant_unzigzag (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [jdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // table_index, quant_value, coefficient
	input  logic [jdq_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // command, table_select
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [jdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // sample, position
	output logic                             m_axis_tlast
);
	import jdq_pkg::*;

	logic                 accept;
	cmd_t                 command;
	logic [SEL_W-1:0]     table_select;
	logic [POS_W-1:0]     table_index;
	logic [STEP_W-1:0]    quant_value;
	logic [SAMPLE_W-1:0]  coefficient;
	logic                 sel_ok;
	logic                 is_coef;

	logic [POS_W-1:0]     coeff_count_q;
	logic                 wr_bank_q;
	logic [1:0]           busy_q;
	logic [1:0]           full_q;

	logic                 qt_we;
	logic                 qt_re;
	logic [TBL_ADDR_W-1:0] qt_addr;
	logic [TBL_ADDR_W-1:0] load_addr;
	logic [TBL_ADDR_W-1:0] coef_addr;
	logic [STEP_W-1:0]    qt_rdata;

	logic                 valid_s1;
	logic signed [SAMPLE_W-1:0] coef_s1;
	logic                 sel_ok_s1;
	logic [POS_W-1:0]     nat_pos_s1;
	logic                 bank_s1;
	logic                 last_s1;

	logic [STEP_W-1:0]    step;
	logic signed [PROD_W-1:0] product;

	logic                 valid_s2;
	logic [SAMPLE_W-1:0]  prod_s2;
	logic [POS_W-1:0]     nat_pos_s2;
	logic                 bank_s2;
	logic                 last_s2;

	logic                 rd_en;
	logic [BLK_ADDR_W-1:0] rd_addr;
	logic [SAMPLE_W-1:0]  rd_data;
	rd_status_t           rd_status;

	assign command      = cmd_t'(s_axis_tuser[0]);
	assign table_select = s_axis_tuser[SEL_W:1];
	assign table_index  = s_axis_tdata[POS_W-1:0];
	assign quant_value  = s_axis_tdata[POS_W+STEP_W-1:POS_W];
	assign coefficient  = s_axis_tdata[POS_W+STEP_W+SAMPLE_W-1:POS_W+STEP_W];

	assign s_axis_tready = !busy_q[wr_bank_q];
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign sel_ok        = ({1'b0, table_select} < 3'(NUM_TABLES));
	assign is_coef       = (command == CMD_COEF);

	assign load_addr = TBL_ADDR_W'({table_select, table_index});
	assign coef_addr = TBL_ADDR_W'({table_select, coeff_count_q});
	assign qt_we     = accept && !is_coef && sel_ok;
	assign qt_re     = accept && is_coef;
	assign qt_addr   = is_coef ? coef_addr : load_addr;

	jdq_qtable_mem u_qtable (
		.clk   (clk),
		.we    (qt_we),
		.re    (qt_re),
		.addr  (qt_addr),
		.wdata (quant_value),
		.rdata (qt_rdata)
	);

	// position counter, bank flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_count_q <= '0;
			wr_bank_q     <= 1'b0;
			busy_q        <= '0;
			full_q        <= '0;
		end else begin
			if (qt_re) begin
				coeff_count_q <= coeff_count_q + 1'b1;
				if (coeff_count_q == LAST_POS) begin
					wr_bank_q         <= !wr_bank_q;
					busy_q[wr_bank_q] <= 1'b1;
				end
			end
			if (valid_s2 && last_s2) begin
				full_q[bank_s2] <= 1'b1;
			end
			if (rd_status.done) begin
				busy_q[rd_status.bank] <= 1'b0;
				full_q[rd_status.bank] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= qt_re;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (qt_re) begin
			coef_s1    <= $signed(coefficient);
			sel_ok_s1  <= sel_ok;
			nat_pos_s1 <= ZZ_TO_NAT[coeff_count_q];
			bank_s1    <= wr_bank_q;
			last_s1    <= (coeff_count_q == LAST_POS);
		end
	end

	// out-of-range selector gives a zero step
	assign step    = sel_ok_s1 ? qt_rdata : '0;
	assign product = coef_s1 * $signed({1'b0, step});

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2    <= product[SAMPLE_W-1:0];
			nat_pos_s2 <= nat_pos_s1;
			bank_s2    <= bank_s1;
			last_s2    <= last_s1;
		end
	end

	jdq_block_mem u_block (
		.clk   (clk),
		.we    (valid_s2),
		.waddr ({bank_s2, nat_pos_s2}),
		.wdata (prod_s2),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	jdq_readout u_readout (
		.clk           (clk),
		.arst_n        (arst_n),
		.full          (full_q),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.status        (rd_status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	`JDQ_ASSERT_NOW(a_no_write_into_read_bank, valid_s2 && rd_status.active, bank_s2 != rd_status.bank, "block store write hits the bank being read out")
	`JDQ_ASSERT_NEXT(a_done_frees_bank, rd_status.done, !busy_q[$past(rd_status.bank)] && !full_q[$past(rd_status.bank)], "bank still held after readout finished")
	`JDQ_ASSERT_NOW(a_read_only_full_bank, rd_en, full_q[rd_addr[BLK_ADDR_W-1]] && busy_q[rd_addr[BLK_ADDR_W-1]], "readout from a bank that is not complete")

endmodule

[sv/jdq_qtable_mem.sv]
// quantization table memory, one port, registered read
module jdq_qtable_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic                           re,
	input  logic [jdq_pkg::TBL_ADDR_W-1:0] addr,
	input  logic [jdq_pkg::STEP_W-1:0]     wdata,
	output logic [jdq_pkg::STEP_W-1:0]     rdata
);
	import jdq_pkg::*;

	logic [STEP_W-1:0] mem [NUM_TABLES * BLOCK_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[sv/jdq_block_mem.sv]
// ping-pong block store, one write and one read port, registered read
module jdq_block_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic [jdq_pkg::BLK_ADDR_W-1:0] waddr,
	input  logic [jdq_pkg::SAMPLE_W-1:0]   wdata,
	input  logic                           re,
	input  logic [jdq_pkg::BLK_ADDR_W-1:0] raddr,
	output logic [jdq_pkg::SAMPLE_W-1:0]   rdata
);
	import jdq_pkg::*;

	logic [SAMPLE_W-1:0] mem [BLK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/jdq_readout.sv]
// reads a full bank out in natural order through an output register and skid stage
module jdq_readout (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [1:0]                        full,
	output logic                              rd_en,
	output logic [jdq_pkg::BLK_ADDR_W-1:0]    rd_addr,
	input  logic [jdq_pkg::SAMPLE_W-1:0]      rd_data,
	output jdq_pkg::rd_status_t               status,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [jdq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // sample, position, zero fill
	output logic                              m_axis_tlast
);
	import jdq_pkg::*;

	typedef enum logic [1:0] {
		RD_IDLE = 2'b01,
		RD_RUN  = 2'b10
	} rd_state_t;

	rd_state_t           state_q;
	logic                bank_q;
	logic [POS_W:0]      issue_cnt_q;
	logic                inflight_s1;
	logic [POS_W-1:0]    inflight_pos_s1;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic [POS_W-1:0]    out_pos_q;
	logic                skid_valid_q;
	logic [SAMPLE_W-1:0] skid_sample_q;
	logic [POS_W-1:0]    skid_pos_q;

	logic       pop;
	logic       last_pop;
	logic [1:0] occ;
	logic [1:0] occ_after;
	logic       issue;

	assign pop       = out_valid_q && m_axis_tready;
	assign last_pop  = pop && (out_pos_q == LAST_POS);
	assign occ       = {1'b0, out_valid_q} + {1'b0, skid_valid_q} + {1'b0, inflight_s1};
	assign occ_after = occ - {1'b0, pop};
	// one read in flight per free slot of output register and skid
	assign issue     = (state_q == RD_RUN) && !issue_cnt_q[POS_W] && (occ_after < 2'd2);

	assign rd_en   = issue;
	assign rd_addr = {bank_q, issue_cnt_q[POS_W-1:0]};

	assign status.done   = last_pop;
	assign status.active = (state_q == RD_RUN);
	assign status.bank   = bank_q;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - SAMPLE_W - POS_W){1'b0}}, out_pos_q, out_sample_q};
	assign m_axis_tlast  = (out_pos_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= RD_IDLE;
			bank_q      <= 1'b0;
			issue_cnt_q <= '0;
			inflight_s1 <= 1'b0;
		end else begin
			inflight_s1 <= issue;
			unique case (state_q)
				RD_IDLE: begin
					if (full[bank_q]) begin
						state_q     <= RD_RUN;
						issue_cnt_q <= '0;
					end
				end
				RD_RUN: begin
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (last_pop) begin
						state_q <= RD_IDLE;
						bank_q  <= !bank_q;
					end
				end
				default: begin
					state_q <= RD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			inflight_pos_s1 <= issue_cnt_q[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= inflight_s1;
				end else begin
					out_valid_q <= inflight_s1;
				end
			end else if (inflight_s1) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_sample_q <= skid_sample_q;
				out_pos_q    <= skid_pos_q;
				if (inflight_s1) begin
					skid_sample_q <= rd_data;
					skid_pos_q    <= inflight_pos_s1;
				end
			end else if (inflight_s1) begin
				out_sample_q <= rd_data;
				out_pos_q    <= inflight_pos_s1;
			end
		end else if (inflight_s1) begin
			skid_sample_q <= rd_data;
			skid_pos_q    <= inflight_pos_s1;
		end
	end

endmodule

[tb/dequant_compare.sv]
`timescale 1ns / 1ps
// stream monitor: predicts dequantized natural-order blocks and compares the output words
module dequant_compare (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [jdq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // table_index, quant_value, coefficient
	input  logic [jdq_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // command, table_select
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [jdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // sample, position
	input  logic                            m_axis_tlast,
	output int                              mismatches,
	output int                              pending
);
	import jdq_pkg::*;

	typedef struct packed {
		logic [15:0] sample;
		logic [5:0]  position;
		logic        last;
	} sample_word_t;

	// zigzag index to natural row-major index
	localparam logic [5:0] NATURAL_POS [64] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

	logic [7:0]   step_table [NUM_TABLES][BLOCK_ENTRIES];
	logic [15:0]  block_samples [BLOCK_ENTRIES];
	logic [5:0]   zz_pos;
	sample_word_t expected_samples [$];
	int           bad_words = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic dequant_word(input logic [IN_TDATA_W-1:0] data,
			input logic [IN_TUSER_W-1:0] user);
		logic [1:0]         sel;
		logic [7:0]         step;
		logic signed [15:0] coef;
		int                 product;
		sample_word_t       word;
		sel = user[2:1];
		coef = data[29:14];
		if (cmd_t'(user[0]) == CMD_LOAD) begin
			if (sel < NUM_TABLES)
				step_table[sel][data[5:0]] = data[13:6];
		end else begin
			step = (sel < NUM_TABLES) ? step_table[sel][zz_pos] : 8'd0;
			product = int'(coef) * int'(step);
			block_samples[NATURAL_POS[zz_pos]] = product[15:0];
			if (zz_pos == 6'd63) begin
				for (int k = 0; k < BLOCK_ENTRIES; k++) begin
					word.sample = block_samples[k];
					word.position = 6'(k);
					word.last = (k == BLOCK_ENTRIES - 1);
					expected_samples.push_back(word);
				end
			end
			zz_pos = zz_pos + 6'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sample_word_t want;
		sample_word_t got;
		if (!arst_n) begin
			zz_pos = '0;
			expected_samples.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.sample = m_axis_tdata[15:0];
				got.position = m_axis_tdata[21:16];
				got.last = m_axis_tlast;
				if (expected_samples.size() == 0) begin
					if (bad_words < 10)
						$display("unexpected word: sample %0d position %0d last %0b",
							$signed(got.sample), got.position, got.last);
					bad_words++;
				end else begin
					want = expected_samples.pop_front();
					if (got.sample !== want.sample || got.position !== want.position ||
							got.last !== want.last) begin
						if (bad_words < 10)
							$display("mismatch: expected sample %0d position %0d last %0b,",
								$signed(want.sample), want.position, want.last,
								" got sample %0d position %0d last %0b",
								$signed(got.sample), got.position, got.last);
						bad_words++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				dequant_word(s_axis_tdata, s_axis_tuser);
			mismatches <= bad_words;
			pending <= expected_samples.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the dequantizer and inverse zigzag block
module testbench;
	import jdq_pkg::*;

	localparam int RANDOM_ITEMS = 270;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;  // table_index, quant_value, coefficient
	logic [IN_TUSER_W-1:0]  s_axis_tuser;  // command, table_select
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // sample, position
	logic                   m_axis_tlast;

	int mismatches;
	int pending;

	bit   loaded [NUM_TABLES][BLOCK_ENTRIES];
	int   coef_pos = 0;
	int   items_sent = 0;
	int   blocks_done = 0;
	bit   calm = 0;
	int   sink_hold = 0;
	bit   sink_calm = 0;

	jpeg_dequant_unzigzag dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	dequant_compare u_compare (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

	// output side back-pressure: mostly short stalls, a few long ones, calm stretches
	always @(posedge clk) begin : sink_pace
		int roll;
		roll = $urandom_range(0, 999);
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (sink_hold != 0) begin
			m_axis_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (roll < 8) begin
			sink_calm <= !sink_calm;
			m_axis_tready <= 1'b1;
		end else if (!sink_calm && roll < 150) begin
			m_axis_tready <= 1'b0;
			sink_hold <= (roll < 25) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_step();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return 8'h00;
		if (roll < 20)
			return 8'hFF;
		if (roll < 30)
			return 8'h01;
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_coef();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 16'h8000;
		if (roll < 10)
			return 16'h7FFF;
		if (roll < 15)
			return 16'hFFFF;
		if (roll < 20)
			return 16'h0000;
		if (roll < 60)
			return 16'($urandom_range(0, 128)) - 16'd64;
		return 16'($urandom);
	endfunction

	// one input word, with an optional gap before it; returns at the accepting edge
	task automatic send_word(input cmd_t cmd, input logic [1:0] sel, input logic [5:0] idx,
			input logic [7:0] qv, input logic [15:0] coef);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, coef, qv, idx};
		s_axis_tuser <= {sel, cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (cmd == CMD_LOAD) begin
			loaded[sel][idx] = 1'b1;
		end else begin
			coef_pos = (coef_pos + 1) % BLOCK_ENTRIES;
		end
	endtask

	task automatic load_step(input logic [1:0] sel, input logic [5:0] idx, input logic [7:0] qv);
		send_word(CMD_LOAD, sel, idx, qv, 16'($urandom));
	endtask

	// a coefficient never reads a step that was not loaded first
	task automatic send_coef(input logic [1:0] sel, input logic [15:0] coef);
		if (!loaded[sel][coef_pos])
			load_step(sel, 6'(coef_pos), pick_step());
		send_word(CMD_COEF, sel, 6'($urandom), 8'($urandom), coef);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int          roll;
		logic [1:0]  block_sel;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of steps and coefficients, unused fields all ones and all zeros
		send_word(CMD_LOAD, 2'd0, 6'd0, 8'hFF, 16'hFFFF);
		send_word(CMD_LOAD, 2'd1, 6'd0, 8'h00, 16'h0000);
		load_step(2'd2, 6'd0, 8'h01);
		load_step(2'd3, 6'd0, 8'h80);
		load_step(2'd0, 6'd63, 8'hFF);
		load_step(2'd1, 6'd1, 8'hFF);
		send_coef(2'd0, 16'h8000);
		send_word(CMD_COEF, 2'd1, 6'h3F, 8'hFF, 16'h7FFF);
		load_step(2'd2, 6'd2, 8'hFF);
		send_coef(2'd2, 16'hFFFF);
		load_step(2'd3, 6'd3, 8'hFE);
		send_word(CMD_COEF, 2'd3, 6'h00, 8'h00, 16'h0000);
		send_coef(2'd0, 16'h0001);
		load_step(2'd1, 6'd5, 8'h00);
		send_coef(2'd1, 16'h7FFF);
		// table rewritten in the middle of a block
		load_step(2'd3, 6'd6, 8'h10);
		send_coef(2'd3, 16'h8000);
		load_step(2'd3, 6'd7, 8'h01);
		send_coef(2'd3, 16'h1234);
		load_step(2'd3, 6'd7, 8'h80);

		items_sent = 0;
		block_sel = 2'($urandom_range(0, 3));
		while (items_sent < RANDOM_ITEMS || coef_pos != 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				load_step(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), pick_step());
			end else begin
				if (roll < 22)
					block_sel = 2'($urandom_range(0, 3));
				send_coef(block_sel, pick_coef());
				if (coef_pos == 0) begin
					blocks_done++;
					calm = ($urandom_range(0, 3) == 0);
					block_sel = 2'($urandom_range(0, 3));
					if (blocks_done == 1 || $urandom_range(0, 3) == 0)
						drain_results();
				end
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
